>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is high
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion, also checked during reset
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> rtl/core/iirl_pkg.sv
// types and constants for the indexed insert/remove list
`timescale 1ns / 1ps

package iirl_pkg;

  localparam int DATA_W       = 64;
  localparam int POS_W        = 6;
  localparam int OP_W         = 3;
  localparam int CAPACITY_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_SET    = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_PUSH   = 3'd4,
    OP_POP    = 3'd5,
    OP_BACK   = 3'd6
  } op_t;

  // op code with no operation behind it, always refused
  localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd7;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_WRITE,
    CMD_SHIFT_UP,
    CMD_SHIFT_DOWN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [DATA_W-1:0] word;
  } cell_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] word_in;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] word_out;
    logic [POS_W-1:0]  length;
    logic              fault;
  } rsp_t;

endpackage

>>> rtl/core/iirl_cell.sv
// one storage cell of the list, shifts with its neighbors on command
`timescale 1ns / 1ps

module iirl_cell import iirl_pkg::*; #(
  parameter int IW  = POS_W,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IW-1:0]     pos,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  output logic [DATA_W-1:0] word
);

  logic              hit;
  logic              above;
  logic [DATA_W-1:0] word_next;

  assign hit   = (pos == IW'(IDX));
  assign above = (IW'(IDX) > pos);

  always_comb begin
    word_next = word;
    unique case (cmd.kind)
      CMD_HOLD: begin
        word_next = word;
      end
      CMD_WRITE: begin
        if (hit) word_next = cmd.word;
      end
      CMD_SHIFT_UP: begin
        if (hit) begin
          word_next = cmd.word;
        end else if (above) begin
          word_next = left;
        end
      end
      CMD_SHIFT_DOWN: begin
        if (hit || above) word_next = right;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

>>> rtl/core/indexed_insert_remove_list.sv
// top level: bounded list of 64-bit words with indexed insert and remove
// requests enter on req (valid/stall), one response per request leaves on rsp.
// ops: get, set, insert, remove, push, pop, back; op code 7 is refused.
// every response carries the entry count after the request and a fault flag;
// a bad position, a full list or an empty list sets fault, returns a zero
// word and leaves the list as it was.
// the words sit in a row of CAPACITY cells; insert writes the position and
// shifts every cell above it up by one place, and remove shifts the cell at
// the position and every cell above it down by one place, in the same cycle.
// the response is registered and shows in the cycle after acceptance.
// one request per cycle while rsp is taken, limited by the
// single response register.
// req_stall is high while a response waits under rsp_stall.
// reset clears the count and the response valid and holds req_stall high;
// cell contents stay undefined until written, and no request can read an
// unwritten cell.
`timescale 1ns / 1ps

module indexed_insert_remove_list import iirl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int UW = $clog2(CAPACITY + 1);
  localparam int IW = (UW > POS_W) ? UW : POS_W;

  logic [UW-1:0]     used;
  logic [UW-1:0]     used_next;
  logic [IW-1:0]     used_x;
  logic [IW-1:0]     pos_x;
  logic [IW-1:0]     last;
  logic [IW-1:0]     cmd_pos;
  logic [IW-1:0]     rd_idx;
  logic              full;
  logic              empty;
  logic              bad;
  logic              has_rd;
  logic              accept;
  cmd_kind_t         kind;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] rd_word;
  logic [DATA_W-1:0] cell_q [CAPACITY];
  logic [IW-1:0]     used_next_x;

  assign req_stall = rst || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  assign used_x = IW'(used);
  assign pos_x  = IW'(req.position);
  assign last   = used_x - 1'b1;
  assign full   = (used == UW'(CAPACITY));
  assign empty  = (used == '0);

  always_comb begin
    kind      = CMD_HOLD;
    cmd_pos   = pos_x;
    rd_idx    = pos_x;
    bad       = 1'b0;
    has_rd    = 1'b0;
    used_next = used;
    unique case (req.op)
      OP_GET: begin
        if (pos_x < used_x) has_rd = 1'b1;
        else bad = 1'b1;
      end
      OP_SET: begin
        if (pos_x < used_x) kind = CMD_WRITE;
        else bad = 1'b1;
      end
      OP_INSERT: begin
        if (pos_x <= used_x && !full) begin
          kind      = CMD_SHIFT_UP;
          used_next = used + 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos_x < used_x) begin
          has_rd    = 1'b1;
          kind      = CMD_SHIFT_DOWN;
          used_next = used - 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      OP_PUSH: begin
        if (!full) begin
          kind      = CMD_WRITE;
          cmd_pos   = used_x;
          used_next = used + 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      OP_POP: begin
        if (!empty) begin
          rd_idx    = last;
          has_rd    = 1'b1;
          used_next = used - 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      OP_BACK: begin
        if (!empty) begin
          rd_idx = last;
          has_rd = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  assign cmd.kind = accept ? kind : CMD_HOLD;
  assign cmd.word = req.word_in;

  // row of cells, each sees both neighbors, with zero past either end
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;

    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_q[g+1];
    end

    iirl_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .pos   (cmd_pos),
      .left  (left),
      .right (right),
      .word  (cell_q[g])
    );
  end

  // read select as an or of matching cells
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (IW'(i) == rd_idx) rd_word = rd_word | cell_q[i];
    end
  end

  assign used_next_x = IW'(used_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      rsp_valid <= 1'b0;
    end else if (accept) begin
      used      <= used_next;
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.word_out <= (has_rd && !bad) ? rd_word : '0;
      rsp.length   <= used_next_x[POS_W-1:0];
      rsp.fault    <= bad;
    end
  end

endmodule

>>> rtl/core/iirl_checker.sv
// port checker for the indexed insert/remove list, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iirl_checker import iirl_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  logic bad_req;

  assign bad_req = req_valid && !req_stall && (req.op == OP_UNKNOWN);

  `ASSERT_ALWAYS(a_idle_after_reset, $past(rst) |-> !rsp_valid)
  `ASSERT_CLK(a_accept_gives_rsp, (req_valid && !req_stall) |=> rsp_valid)
  `ASSERT_CLK(a_bad_op_faults, bad_req |=> (rsp_valid && rsp.fault && rsp.word_out == '0))
  `ASSERT_CLK(a_rsp_holds, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))

endmodule

bind indexed_insert_remove_list iirl_checker u_iirl_checker (.*);
